// ===== src/multipole_potential_2d_evaluator_top_macros.svh =====
// Assertion macros used by the evaluator's engine (mpe_back).
`ifndef MULTIPOLE_POTENTIAL_2D_EVALUATOR_TOP_MACROS_SVH
`define MULTIPOLE_POTENTIAL_2D_EVALUATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MPE_ASSERT(lbl, prop, msg)
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/mpe_pkg.sv =====
// Shared types, constants and rounding helpers of the multipole evaluator.
package mpe_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int MAX_TERMS_DEF = 16;

  localparam logic signed [24:0] LN2_Q24    = 25'sd11629080;
  localparam logic signed [28:0] INV2PI_Q30 = 29'sd170891319;
  localparam logic signed [63:0] ACC_LIMIT  = 64'sd17179869184;

  localparam logic [1:0] REG_CENTER_X   = 2'd0;
  localparam logic [1:0] REG_CENTER_Y   = 2'd1;
  localparam logic [1:0] REG_TERM_COUNT = 2'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  // One queue entry: val0/val1 carry the coefficients of a write or the
  // centred point of an evaluation.
  typedef struct packed {
    op_t                op;
    logic [3:0]         idx;
    logic signed [31:0] val0;
    logic signed [31:0] val1;
    logic               dsat;
  } item_t;

  function automatic logic signed [65:0] sx66(input logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  // Round half towards plus infinity, then arithmetic shift right.
  function automatic logic signed [65:0] rsh_round(input logic signed [65:0] v,
                                                   input int unsigned sh);
    logic signed [65:0] half;
    half = 66'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  // Returns {clamped, value}.
  function automatic logic [32:0] clamp32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/mpe_front.sv =====
// Front end: classifies incoming items and centres evaluation points.
module mpe_front (
  input  logic               in_operation,
  input  logic [3:0]         in_term_index,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  output mpe_pkg::item_t     item
);

  logic signed [32:0] dx_w;
  logic signed [32:0] dy_w;
  logic [32:0]        dx_c;
  logic [32:0]        dy_c;

  always_comb begin
    dx_w = 33'(in_point_x) - 33'(center_x);
    dy_w = 33'(in_point_y) - 33'(center_y);
    dx_c = mpe_pkg::clamp32(66'(dx_w));
    dy_c = mpe_pkg::clamp32(66'(dy_w));
    item.idx = in_term_index;
    if (in_operation == mpe_pkg::OP_EVAL) begin
      item.op   = mpe_pkg::OP_EVAL;
      item.val0 = dx_c[31:0];
      item.val1 = dy_c[31:0];
      item.dsat = dx_c[32] | dy_c[32];
    end else begin
      item.op   = mpe_pkg::OP_WRITE;
      item.val0 = in_coef_a;
      item.val1 = in_coef_b;
      item.dsat = 1'b0;
    end
  end

endmodule

// ===== src/mpe_queue.sv =====
// Two-entry queue between the front end and the evaluation engine.
module mpe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mpe_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output mpe_pkg::item_t rdata,
  output logic           empty
);

  mpe_pkg::item_t mem_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== src/mpe_back.sv =====
// Evaluation engine: coefficient table, log and reciprocal units, term loop.
`include "multipole_potential_2d_evaluator_top_macros.svh"
module mpe_back #(
  parameter int MAX_TERMS = mpe_pkg::MAX_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  mpe_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic [4:0]         term_count,
  input  logic               out_pop,
  output logic               out_empty,
  output logic signed [31:0] out_potential,
  output logic               out_at_center,
  output logic               out_saturated
);

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int K_W   = $clog2(MAX_TERMS + 1);
  localparam int F     = mpe_pkg::FRAC_BITS;
  localparam int DIV_STEPS = 33;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SUM, S_NORM, S_DIV, S_LN1, S_LN2, S_LN3, S_LN4,
    S_TP, S_TS, S_F1, S_F2, S_F3, S_DONE
  } state_t;

  state_t state_r;

  logic signed [31:0] cos_mem [MAX_TERMS];
  logic signed [31:0] sin_mem [MAX_TERMS];
  logic signed [31:0] rd_c_r, rd_s_r;
  logic [IDX_W-1:0]   rd_addr;

  logic signed [31:0] dx_r, dy_r, a0_r, wr_r, wi_r, pr_r, pi_r, lnr_r;
  logic               sat_r;
  logic signed [63:0] sq_x_r, sq_y_r;
  logic [63:0]        s_r, t_r, rr_r, ri_r;
  logic [5:0]         m_r, cnt_r;
  logic [30:0]        y_r;
  logic [F-1:0]       f_r;
  logic [32:0]        qr_r, qi_r;
  logic               ovr_r, ovi_r, negr_r, negi_r, injr_r, inji_r;
  logic signed [63:0] lnp_r, a0p_r, acc_r, fp_r;
  logic signed [63:0] m_cp_r, m_sp_r, m_rr_r, m_ii_r, m_ri_r, m_ir_r;
  logic signed [35:0] accc_r;
  logic [K_W-1:0]     n_r, k_r;
  logic               out_valid_r, atc_r, osat_r;
  logic signed [31:0] pot_r;
  logic signed [31:0] res_pot_r;
  logic               res_atc_r, res_sat_r;

  // Helper nets.
  logic [63:0]        s_sum;
  logic [31:0]        magr, magi;
  logic [6:0]         nsh;
  logic               ntop_zero;
  logic [63:0]        t_nxt;
  logic [5:0]         m_nxt;
  logic [61:0]        ysq;
  logic [31:0]        yv;
  logic [64:0]        rr_sh, ri_sh;
  logic               rr_ge, ri_ge;
  logic signed [7:0]  lm;
  logic signed [F+7:0] lval;
  logic [32:0]        qr_q, qi_q;
  logic signed [34:0] wr_v, wi_v;
  logic [32:0]        wr_c, wi_c, lnr_c, nr_c, ni_c, res_c;
  logic signed [65:0] t_rnd;
  logic [6:0]         tc7, n7;
  logic               load_out;

  always_comb begin
    s_sum     = $unsigned(sq_x_r) + $unsigned(sq_y_r);
    magr      = dx_r[31] ? 32'(-33'(dx_r)) : 32'(dx_r);
    magi      = dy_r[31] ? 32'(-33'(dy_r)) : 32'(dy_r);
    nsh       = 7'd32 >> cnt_r[2:0];
    ntop_zero = ((t_r >> (7'd64 - nsh)) == 64'd0);
    t_nxt     = ntop_zero ? (t_r << nsh) : t_r;
    m_nxt     = ntop_zero ? (m_r - nsh[5:0]) : m_r;
    ysq       = 62'(y_r) * 62'(y_r);
    yv        = ysq[61:30];
    rr_sh     = {rr_r, (cnt_r == 6'd0) ? injr_r : 1'b0};
    ri_sh     = {ri_r, (cnt_r == 6'd0) ? inji_r : 1'b0};
    rr_ge     = (rr_sh >= {1'b0, s_r});
    ri_ge     = (ri_sh >= {1'b0, s_r});
    lm        = $signed({2'b00, m_r}) - 8'sd32;
    lval      = {lm, f_r};
    qr_q      = ovr_r ? 33'h1_0000_0000 : qr_r;
    qi_q      = ovi_r ? 33'h1_0000_0000 : qi_r;
    wr_v      = negr_r ? -$signed({2'b00, qr_q}) : $signed({2'b00, qr_q});
    wi_v      = negi_r ? -$signed({2'b00, qi_q}) : $signed({2'b00, qi_q});
    wr_c      = mpe_pkg::clamp32(66'(wr_v));
    wi_c      = mpe_pkg::clamp32(66'(wi_v));
    lnr_c     = mpe_pkg::clamp32(mpe_pkg::rsh_round(mpe_pkg::sx66(lnp_r), 25));
    t_rnd     = mpe_pkg::rsh_round(mpe_pkg::sx66(m_cp_r) - mpe_pkg::sx66(m_sp_r), F);
    nr_c      = mpe_pkg::clamp32(mpe_pkg::rsh_round(
                  mpe_pkg::sx66(m_rr_r) - mpe_pkg::sx66(m_ii_r), F));
    ni_c      = mpe_pkg::clamp32(mpe_pkg::rsh_round(
                  mpe_pkg::sx66(m_ri_r) + mpe_pkg::sx66(m_ir_r), F));
    res_c     = mpe_pkg::clamp32(mpe_pkg::rsh_round(mpe_pkg::sx66(fp_r), 30));
    tc7       = {2'b00, term_count};
    if (tc7 == 7'd0) begin
      n7 = 7'd1;
    end else if (tc7 > 7'(MAX_TERMS)) begin
      n7 = 7'(MAX_TERMS);
    end else begin
      n7 = tc7;
    end
    unique case (state_r)
      S_SQ:    rd_addr = '0;
      S_LN4:   rd_addr = IDX_W'(1);
      S_TS:    rd_addr = IDX_W'(k_r + 1'b1);
      default: rd_addr = '0;
    endcase
  end

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_potential = pot_r;
  assign out_at_center = atc_r;
  assign out_saturated = osat_r;

  // Coefficient table with registered read.
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == mpe_pkg::OP_WRITE && {3'b000, q_item.idx} < 7'(MAX_TERMS))
    begin
      cos_mem[IDX_W'(q_item.idx)] <= q_item.val0;
      sin_mem[IDX_W'(q_item.idx)] <= q_item.val1;
    end
    rd_c_r <= cos_mem[rd_addr];
    rd_s_r <= sin_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r && !load_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_item.op == mpe_pkg::OP_WRITE) begin
              res_pot_r <= '0;
              res_atc_r <= 1'b0;
              res_sat_r <= 1'b0;
              state_r   <= S_DONE;
            end else begin
              dx_r    <= q_item.val0;
              dy_r    <= q_item.val1;
              sat_r   <= q_item.dsat;
              n_r     <= K_W'(n7);
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          sq_x_r  <= dx_r * dx_r;
          sq_y_r  <= dy_r * dy_r;
          state_r <= S_SUM;
        end
        S_SUM: begin
          a0_r <= rd_c_r;
          if (s_sum == 64'd0) begin
            res_pot_r <= rd_c_r[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            res_atc_r <= 1'b1;
            res_sat_r <= 1'b1;
            state_r   <= S_DONE;
          end else begin
            s_r     <= s_sum;
            t_r     <= s_sum;
            m_r     <= 6'd63;
            cnt_r   <= 6'd0;
            rr_r    <= 64'(magr >> 1);
            ri_r    <= 64'(magi >> 1);
            ovr_r   <= (64'(magr >> 1) >= s_sum);
            ovi_r   <= (64'(magi >> 1) >= s_sum);
            injr_r  <= magr[0];
            inji_r  <= magi[0];
            negr_r  <= dx_r[31];
            negi_r  <= !dy_r[31] && (dy_r != 32'sd0);
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          t_r <= t_nxt;
          m_r <= m_nxt;
          if (cnt_r == 6'd5) begin
            y_r     <= t_nxt[63:33];
            f_r     <= '0;
            cnt_r   <= 6'd0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_DIV: begin
          rr_r <= rr_ge ? 64'(rr_sh - {1'b0, s_r}) : rr_sh[63:0];
          ri_r <= ri_ge ? 64'(ri_sh - {1'b0, s_r}) : ri_sh[63:0];
          qr_r <= {qr_r[31:0], rr_ge};
          qi_r <= {qi_r[31:0], ri_ge};
          if (cnt_r < 6'(F)) begin
            if (yv[31]) begin
              y_r <= yv[31:1];
              f_r[F - 1 - int'(cnt_r)] <= 1'b1;
            end else begin
              y_r <= yv[30:0];
            end
          end
          if (cnt_r == 6'(DIV_STEPS - 1)) begin
            cnt_r   <= 6'd0;
            state_r <= S_LN1;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_LN1: begin
          lnp_r   <= 64'(lval * mpe_pkg::LN2_Q24);
          wr_r    <= wr_c[31:0];
          wi_r    <= wi_c[31:0];
          pr_r    <= wr_c[31:0];
          pi_r    <= wi_c[31:0];
          sat_r   <= sat_r | wr_c[32] | wi_c[32];
          state_r <= S_LN2;
        end
        S_LN2: begin
          lnr_r   <= lnr_c[31:0];
          sat_r   <= sat_r | lnr_c[32];
          state_r <= S_LN3;
        end
        S_LN3: begin
          a0p_r   <= a0_r * lnr_r;
          state_r <= S_LN4;
        end
        S_LN4: begin
          acc_r   <= 64'(mpe_pkg::rsh_round(-mpe_pkg::sx66(a0p_r), F));
          k_r     <= K_W'(1);
          state_r <= (n_r > K_W'(1)) ? S_TP : S_F1;
        end
        S_TP: begin
          m_cp_r  <= rd_c_r * pr_r;
          m_sp_r  <= rd_s_r * pi_r;
          m_rr_r  <= pr_r * wr_r;
          m_ii_r  <= pi_r * wi_r;
          m_ri_r  <= pr_r * wi_r;
          m_ir_r  <= pi_r * wr_r;
          state_r <= S_TS;
        end
        S_TS: begin
          acc_r <= acc_r + 64'(t_rnd);
          k_r   <= k_r + 1'b1;
          if ((k_r + 1'b1) < n_r) begin
            pr_r    <= nr_c[31:0];
            pi_r    <= ni_c[31:0];
            sat_r   <= sat_r | nr_c[32] | ni_c[32];
            state_r <= S_TP;
          end else begin
            state_r <= S_F1;
          end
        end
        S_F1: begin
          if (acc_r > mpe_pkg::ACC_LIMIT) begin
            accc_r <= 36'(mpe_pkg::ACC_LIMIT);
            sat_r  <= 1'b1;
          end else if (acc_r < -mpe_pkg::ACC_LIMIT) begin
            accc_r <= 36'(-mpe_pkg::ACC_LIMIT);
            sat_r  <= 1'b1;
          end else begin
            accc_r <= 36'(acc_r);
          end
          state_r <= S_F2;
        end
        S_F2: begin
          fp_r    <= accc_r * mpe_pkg::INV2PI_Q30;
          state_r <= S_F3;
        end
        S_F3: begin
          res_pot_r <= res_c[31:0];
          res_atc_r <= 1'b0;
          res_sat_r <= sat_r | res_c[32];
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            pot_r       <= res_pot_r;
            atc_r       <= res_atc_r;
            osat_r      <= res_sat_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MPE_ASSERT(a_center_saturates, !(out_valid_r && atc_r) || osat_r, "centre result without saturation flag")
  `MPE_ASSERT(a_term_in_range, !(state_r == S_TP) || (k_r < n_r), "term index beyond term count")
  `MPE_ASSERT_NEXT(a_pop_leaves_idle, q_pop, state_r != S_IDLE, "engine stayed idle after taking an item")

endmodule

// ===== src/multipole_potential_2d_evaluator_top.sv =====
// Top level of the 2D multipole potential evaluator with its register port.
// Items enter through a queue-like port (push/full) and results leave through
// another (empty/pop); a two-entry queue sits between the front end, which
// centres each evaluation point, and the evaluation engine, which runs one item
// at a time. A coefficient write passes through the engine's idle and done
// states only. An evaluation runs a 6-step leading-one search, a 33-step
// restoring divider forming 1/z (the 16-step log unit runs alongside it), and
// a term loop that performs one complex multiply-accumulate per harmonic. A
// point equal to the centre skips these and returns a saturated result. The
// front end keeps accepting beats while the engine works and while a finished
// result waits on the result port, until the queue fills.
module multipole_potential_2d_evaluator_top #(
  parameter int MAX_TERMS = mpe_pkg::MAX_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               push,
  output logic               full,
  input  logic               in_operation,
  input  logic [3:0]         in_term_index,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  // Result channel.
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_potential,
  output logic               out_at_center,
  output logic               out_saturated,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [31:0] center_x_r;
  logic signed [31:0] center_y_r;
  logic [4:0]         term_count_r;
  logic               cfg_wr;

  mpe_pkg::item_t     fe_item;
  mpe_pkg::item_t     q_item;
  logic               q_empty;
  logic               q_pop;

  // The register port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      term_count_r <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mpe_pkg::REG_CENTER_X:   center_x_r   <= pwdata;
        mpe_pkg::REG_CENTER_Y:   center_y_r   <= pwdata;
        mpe_pkg::REG_TERM_COUNT: term_count_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mpe_pkg::REG_CENTER_X:   prdata = center_x_r;
      mpe_pkg::REG_CENTER_Y:   prdata = center_y_r;
      mpe_pkg::REG_TERM_COUNT: prdata = {27'd0, term_count_r};
      default:                 prdata = '0;
    endcase
  end

  // The front end centres the point as the beat arrives, so the queue holds
  // ready-to-use differences together with their clamp flag.
  mpe_front u_front (
    .in_operation  (in_operation),
    .in_term_index (in_term_index),
    .in_coef_a     (in_coef_a),
    .in_coef_b     (in_coef_b),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .center_x      (center_x_r),
    .center_y      (center_y_r),
    .item          (fe_item)
  );

  mpe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fe_item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  // The engine holds the coefficient table, so writes and evaluations stay
  // in arrival order.
  mpe_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .term_count    (term_count_r),
    .out_pop       (pop),
    .out_empty     (empty),
    .out_potential (out_potential),
    .out_at_center (out_at_center),
    .out_saturated (out_saturated)
  );

endmodule

// ===== sim/multipole_potential_2d_evaluator_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts every result beat of the evaluator and compares it with the block.
module multipole_potential_2d_evaluator_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic               in_operation,
  input  logic [3:0]         in_term_index,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] out_potential,
  input  logic               out_at_center,
  input  logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fails,
  output int                 pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] potential;
    logic               at_center;
    logic               saturated;
  } potential_t;

  localparam wide_t HI32    = 128'sd2147483647;
  localparam wide_t LO32    = -128'sd2147483648;
  localparam wide_t INV2PI  = 128'sd170891319;
  localparam wide_t LN2     = 128'sd11629080;
  localparam wide_t ACC_MAX = 128'sd17179869184;

  logic signed [31:0] center_x, center_y;
  logic [4:0]         term_count;
  logic signed [31:0] cos_coef [16];
  logic signed [31:0] sin_coef [16];
  potential_t         expected_potentials [$];

  function automatic wide_t round_shift(input wide_t v, input int sh);
    return (v + (128'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic wide_t clip32(input wide_t v, inout logic sat);
    if (v > HI32) begin
      sat = 1'b1;
      return HI32;
    end
    if (v < LO32) begin
      sat = 1'b1;
      return LO32;
    end
    return v;
  endfunction

  // One component of w = 1/z: num * 2^32 / s, truncated toward zero.
  function automatic wide_t invert_part(input wide_t num, input wide_t s, inout logic sat);
    wide_t mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< 32) / s;
    if (q > (128'sd1 <<< 32)) q = 128'sd1 <<< 32;
    return clip32((num < 0) ? -q : q, sat);
  endfunction

  // ln of the radius, from log2 of the squared radius by repeated squaring.
  function automatic wide_t log_radius(input wide_t s, inout logic sat);
    int    m;
    wide_t y, f, l;
    m = 63;
    while (s[m] == 1'b0) m--;
    y = (m >= 30) ? (s >>> (m - 30)) : (s <<< (30 - m));
    f = 0;
    for (int i = 1; i <= mpe_pkg::FRAC_BITS; i++) begin
      y = (y * y) >>> 30;
      if (y >= 128'sd2147483648) begin
        y = y >>> 1;
        f = f | (128'sd1 <<< (mpe_pkg::FRAC_BITS - i));
      end
    end
    l = wide_t'(m - 2 * mpe_pkg::FRAC_BITS) * (128'sd1 <<< mpe_pkg::FRAC_BITS) + f;
    return clip32(round_shift(l * LN2, 25), sat);
  endfunction

  function automatic potential_t evaluate_point(input logic signed [31:0] px,
                                                input logic signed [31:0] py);
    potential_t r;
    logic       sat;
    int         n;
    wide_t      dx, dy, s, acc, wr, wi, pr, pim, t, nr, ni;
    sat = 1'b0;
    r = '0;
    n = (term_count == 0) ? 1 : (term_count > 16) ? 16 : int'(term_count);
    dx = clip32(wide_t'(px) - wide_t'(center_x), sat);
    dy = clip32(wide_t'(py) - wide_t'(center_y), sat);
    s = dx * dx + dy * dy;
    if (s == 0) begin
      r.potential = (cos_coef[0] < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      r.at_center = 1'b1;
      r.saturated = 1'b1;
      return r;
    end
    acc = round_shift(-(wide_t'(cos_coef[0]) * log_radius(s, sat)), mpe_pkg::FRAC_BITS);
    wr = invert_part(dx, s, sat);
    wi = invert_part(-dy, s, sat);
    pr = wr;
    pim = wi;
    for (int k = 1; k < n; k++) begin
      t = wide_t'(cos_coef[k]) * pr - wide_t'(sin_coef[k]) * pim;
      acc = acc + round_shift(t, mpe_pkg::FRAC_BITS);
      if (k + 1 < n) begin
        nr = round_shift(pr * wr - pim * wi, mpe_pkg::FRAC_BITS);
        ni = round_shift(pr * wi + pim * wr, mpe_pkg::FRAC_BITS);
        pr = clip32(nr, sat);
        pim = clip32(ni, sat);
      end
    end
    if (acc > ACC_MAX) begin
      acc = ACC_MAX;
      sat = 1'b1;
    end
    if (acc < -ACC_MAX) begin
      acc = -ACC_MAX;
      sat = 1'b1;
    end
    r.potential = 32'(clip32(round_shift(acc * INV2PI, 30), sat));
    r.saturated = sat;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %h, expected %h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    center_x = '0;
    center_y = '0;
    term_count = 5'd1;
  end

  always @(posedge clk) begin
    potential_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mpe_pkg::REG_CENTER_X:   center_x = pwdata;
          mpe_pkg::REG_CENTER_Y:   center_y = pwdata;
          mpe_pkg::REG_TERM_COUNT: term_count = pwdata[4:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_potentials.size() == 0) begin
          report("unexpected result beat, potential", out_potential, 32'h0);
        end else begin
          want = expected_potentials.pop_front();
          if (out_potential !== want.potential)
            report("potential", out_potential, want.potential);
          if (out_at_center !== want.at_center)
            report("at_center", 32'(out_at_center), 32'(want.at_center));
          if (out_saturated !== want.saturated)
            report("saturated", 32'(out_saturated), 32'(want.saturated));
        end
      end
      if (push && !full) begin
        if (mpe_pkg::op_t'(in_operation) == mpe_pkg::OP_WRITE) begin
          cos_coef[in_term_index] = in_coef_a;
          sin_coef[in_term_index] = in_coef_b;
          expected_potentials.push_back('0);
        end else begin
          expected_potentials.push_back(evaluate_point(in_point_x, in_point_y));
        end
      end
      pending = expected_potentials.size();
    end
  end

endmodule

// ===== sim/multipole_potential_2d_evaluator_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives the evaluator with directed and random beats and gives the verdict.
module multipole_potential_2d_evaluator_top_test;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic               in_operation;
  logic [3:0]         in_term_index;
  logic signed [31:0] in_coef_a, in_coef_b, in_point_x, in_point_y;
  logic               empty;
  logic               pop;
  logic signed [31:0] out_potential;
  logic               out_at_center, out_saturated;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fails, pending;

  // Stimulus-side copy of the centre, so that points can be aimed near it.
  logic signed [31:0] aim_x, aim_y;
  // Random gaps on both sides are allowed while this is set.
  bit                 idling;
  // Set by the sender to ask the receiver for one long hold-off.
  bit                 stall_req;

  multipole_potential_2d_evaluator_top dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_operation(in_operation), .in_term_index(in_term_index),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .empty(empty), .pop(pop),
    .out_potential(out_potential), .out_at_center(out_at_center),
    .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  multipole_potential_2d_evaluator_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_operation(in_operation), .in_term_index(in_term_index),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .empty(empty), .pop(pop),
    .out_potential(out_potential), .out_at_center(out_at_center),
    .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run must end well inside this; the slowest correct run is a few hundred
  // microseconds including every stall and gap.
  initial begin
    #3_000_000;
    $display("FAIL multipole_potential_2d_evaluator_top");
    $finish;
  end

  // Offers one beat, keeping push high from the previous beat when no gap is
  // taken, and returns at the edge on which the block accepted it.
  task automatic send_beat(input mpe_pkg::op_t op, input logic [3:0] idx,
                           input logic signed [31:0] a, input logic signed [31:0] b,
                           input logic signed [31:0] x, input logic signed [31:0] y);
    if (idling && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    in_operation <= op;
    in_term_index <= idx;
    in_coef_a <= a;
    in_coef_b <= b;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (full);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers are only rewritten once the block has drained; a further pause
  // covers the engine's longest evaluation.
  task automatic set_config(input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic [4:0] terms);
    push <= 1'b0;
    wait (pending == 0);
    repeat (90) @(posedge clk);
    write_reg(mpe_pkg::REG_CENTER_X, cx);
    write_reg(mpe_pkg::REG_CENTER_Y, cy);
    write_reg(mpe_pkg::REG_TERM_COUNT, {27'd0, terms});
    aim_x = cx;
    aim_y = cy;
  endtask

  function automatic logic signed [31:0] small_value();
    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic logic signed [31:0] any_value();
    return $urandom();
  endfunction

  // Offsets spread over several decades so that 1/z ranges from tiny to clamped.
  function automatic logic signed [31:0] offset_value();
    int sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0: return $signed($urandom_range(0, 16)) - 8;
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      if ($urandom_range(0, 1))
        send_beat(mpe_pkg::OP_WRITE, 4'($urandom_range(0, 15)), small_value(),
                  small_value(), any_value(), any_value());
      else
        send_beat(mpe_pkg::OP_WRITE, 4'($urandom_range(0, 15)), any_value(), any_value(),
                  any_value(), any_value());
    end else if (pick < 33) begin
      send_beat(mpe_pkg::OP_EVAL, 4'($urandom_range(0, 15)), any_value(), any_value(),
                aim_x, aim_y);
    end else if (pick < 85) begin
      send_beat(mpe_pkg::OP_EVAL, 4'($urandom_range(0, 15)), any_value(), any_value(),
                aim_x + offset_value(), aim_y + offset_value());
    end else begin
      send_beat(mpe_pkg::OP_EVAL, 4'($urandom_range(0, 15)), any_value(), any_value(),
                any_value(), any_value());
    end
  endtask

  // Receiver: random pop bursts, one long hold-off on request, none at the end.
  initial begin
    pop <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        pop <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (idling && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    in_operation <= mpe_pkg::OP_WRITE;
    in_term_index <= '0;
    in_coef_a <= '0;
    in_coef_b <= '0;
    in_point_x <= '0;
    in_point_y <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idling = 1'b0;
    stall_req = 1'b0;
    aim_x = '0;
    aim_y = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole term table first so no evaluation ever reads an unwritten
    // entry. Entry 0 starts negative so the centre case saturates downwards.
    send_beat(mpe_pkg::OP_WRITE, 4'd0, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000);
    send_beat(mpe_pkg::OP_WRITE, 4'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, '0);
    for (int i = 2; i < 16; i++)
      send_beat(mpe_pkg::OP_WRITE, i[3:0], small_value(), small_value(), '0, '0);
    // Point at the centre with a negative log coefficient, then extreme points.
    send_beat(mpe_pkg::OP_EVAL, 4'd15, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, '0);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, 32'sh8000_0000, 32'sh8000_0000);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, 32'sh0001_0000, '0);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'sh0000_0001);
    // Positive log coefficient at the centre saturates upwards.
    send_beat(mpe_pkg::OP_WRITE, 4'd0, 32'sh0001_0000, '0, '0, '0);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, '0, '0);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, 32'sh0002_0000, 32'sh0003_0000);

    // Full term count with extreme centres: the differences themselves clamp.
    set_config(32'sh7FFF_FFFF, 32'sh8000_0000, 5'd16);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_beat(mpe_pkg::OP_EVAL, 4'd0, '0, '0, 32'sh7FFF_FFF0, 32'sh8000_0010);

    idling = 1'b1;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_config('0, '0, 5'd16);
        1: set_config(any_value(), any_value(), 5'd0);
        2: set_config(small_value(), small_value(), 5'd31);
        3: set_config('0, '0, 5'd1);
        4: set_config(any_value(), any_value(), 5'($urandom_range(2, 16)));
        5: set_config(32'sh8000_0000, 32'sh7FFF_FFFF, 5'd17);
        default: set_config(small_value(), small_value(), 5'($urandom_range(1, 16)));
      endcase
      if (phase == 1) stall_req = 1'b1;
      if (phase == 6) idling = 1'b0;
      for (int i = 0; i < 75; i++) begin
        if (phase == 3 && i == 40) begin
          // Let the block drain completely before carrying on.
          push <= 1'b0;
          wait (pending == 0);
          @(posedge clk);
        end
        random_beat();
      end
    end

    push <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("PASS multipole_potential_2d_evaluator_top");
    end else begin
      $display("FAIL multipole_potential_2d_evaluator_top");
    end
    $finish;
  end

endmodule
